>>> sv/knnbc_pkg.sv
`timescale 1ns / 1ps

package knnbc_pkg;

  // Fixed field widths of the stream items.
  localparam int FEAT_W     = 16;
  localparam int FEAT_SLOTS = 8;
  localparam int DIFF_SQ_W  = 2 * FEAT_W;
  localparam int DIST_W     = 35;
  localparam int VOTE_W     = 3;

  // Input tdata: eight features, then the label, padded to whole bytes.
  localparam int LABEL_BIT  = FEAT_SLOTS * FEAT_W;
  localparam int IN_TDATA_W = ((LABEL_BIT + 1 + 7) / 8) * 8;

  // Output tdata: class, ones count, zeros count, padded to a byte.
  localparam int OUT_BITS    = 1 + 2 * VOTE_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Item kinds carried on tuser.
  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_ROW   = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_INSERT,
    ST_VOTE
  } knnbc_state_t;

  // Controls from the sequencer to the shared distance unit.
  typedef struct packed {
    logic clear;
    logic step;
    logic drain;
  } mac_ctrl_t;

endpackage

>>> sv/knnbc_mac.sv
`timescale 1ns / 1ps

module knnbc_mac
  import knnbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mac_ctrl_t           ctrl,
  input  logic [FEAT_W-1:0]   a,
  input  logic [FEAT_W-1:0]   b,
  output logic [DIST_W-1:0]   acc
);

  logic [FEAT_W-1:0]    diff;
  logic [DIFF_SQ_W-1:0] prod_r;
  logic [DIFF_SQ_W-1:0] prod_nxt;
  logic                 pv_r;
  logic                 pv_nxt;
  logic [DIST_W-1:0]    acc_r;
  logic [DIST_W-1:0]    acc_nxt;

  // Absolute difference of one feature pair, then its square.
  assign diff     = (a >= b) ? (a - b) : (b - a);
  assign prod_nxt = diff * diff;

  // The product is registered and added to the sum in the following cycle.
  always_comb begin
    acc_nxt = acc_r;
    pv_nxt  = pv_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
      pv_nxt  = 1'b0;
    end else if (ctrl.step) begin
      if (pv_r) begin
        acc_nxt = acc_r + DIST_W'(prod_r);
      end
      pv_nxt = 1'b1;
    end else if (ctrl.drain) begin
      if (pv_r) begin
        acc_nxt = acc_r + DIST_W'(prod_r);
      end
      pv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctrl.step) begin
      prod_r <= prod_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> sv/knn_binary_classifier.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_      input      tuser: func; tdata: feature_0..feature_7, label; tlast: last_row
// out_     output     tdata: predicted_class, votes_one, votes_zero
//
// A query transaction is accepted while idle and stores the features.
// A training row passes through the accepting idle state, one
// subtract-square-accumulate per feature through the shared unit, a drain
// state and an insert into the sorted neighbor list.
// A last row adds a vote state, and waits there while an earlier result
// is still held in the output register. Reset empties the list and zeroes
// the query; in_tready is low while a row is in progress.

module knn_binary_classifier
  import knnbc_pkg::*;
#(
  parameter int NEIGHBOURS = 5,
  parameter int FEATURES   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [127:0] feature_0..feature_7 (16 bits each, feature_0 lowest), [128] label
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] predicted_class, [3:1] votes_one, [6:4] votes_zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int CW = $clog2(NEIGHBOURS + 1);

  knnbc_state_t state_r;
  knnbc_state_t state_nxt;

  logic [FW-1:0]     cnt_r;
  logic [FW-1:0]     cnt_nxt;
  logic [FEAT_W-1:0] query_r [FEATURES];
  logic [FEAT_W-1:0] row_r   [FEATURES];
  logic              label_r;
  logic              last_r;

  logic [DIST_W-1:0] dist_r  [NEIGHBOURS];
  logic              lab_r   [NEIGHBOURS];
  logic [NEIGHBOURS-1:0] valid_r;
  logic [CW-1:0]     ones_r;
  logic [CW-1:0]     zeros_r;

  logic [DIST_W-1:0] dist_ins [NEIGHBOURS];
  logic              lab_ins  [NEIGHBOURS];
  logic [NEIGHBOURS-1:0] valid_ins;
  logic [NEIGHBOURS-1:0] closer;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic              in_fire;
  logic              load_query;
  logic              load_row;
  logic              do_insert;
  logic              do_vote;
  mac_ctrl_t         mac_ctrl;
  logic [DIST_W-1:0] row_dist;

  assign in_fire = in_tvalid && in_tready;

  // Shared distance unit.
  knnbc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a     (query_r[cnt_r]),
    .b     (row_r[cnt_r]),
    .acc   (row_dist)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == FUNC_ROW)) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt_r == FW'(FEATURES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        state_nxt = last_r ? ST_VOTE : ST_IDLE;
      end
      ST_VOTE: begin
        if (!out_valid_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready      = 1'b0;
    mac_ctrl       = '0;
    do_insert      = 1'b0;
    do_vote        = 1'b0;
    cnt_nxt        = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        mac_ctrl.clear = 1'b1;
        cnt_nxt        = '0;
      end
      ST_MAC: begin
        mac_ctrl.step = 1'b1;
        cnt_nxt       = cnt_r + FW'(1);
      end
      ST_DRAIN: begin
        mac_ctrl.drain = 1'b1;
      end
      ST_INSERT: begin
        do_insert = 1'b1;
      end
      ST_VOTE: begin
        do_vote = !out_valid_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign load_query = in_fire && (in_tuser == FUNC_QUERY);
  assign load_row   = in_fire && (in_tuser == FUNC_ROW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Query and row feature registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < FEATURES; f++) begin
        query_r[f] <= '0;
      end
    end else if (load_query) begin
      for (int f = 0; f < FEATURES; f++) begin
        query_r[f] <= in_tdata[f*FEAT_W +: FEAT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_row) begin
      for (int f = 0; f < FEATURES; f++) begin
        row_r[f] <= in_tdata[f*FEAT_W +: FEAT_W];
      end
      label_r <= in_tdata[LABEL_BIT];
      last_r  <= in_tlast;
    end
  end

  // Sorted insertion: each slot compares against the new distance, and the
  // first closer slot takes the new row while the rest shift down by one.
  for (genvar i = 0; i < NEIGHBOURS; i++) begin : g_slot
    assign closer[i] = !valid_r[i] || (row_dist < dist_r[i]);
    if (i == 0) begin : g_head
      always_comb begin
        if (closer[i]) begin
          dist_ins[i]  = row_dist;
          lab_ins[i]   = label_r;
          valid_ins[i] = 1'b1;
        end else begin
          dist_ins[i]  = dist_r[i];
          lab_ins[i]   = lab_r[i];
          valid_ins[i] = valid_r[i];
        end
      end
    end else begin : g_tail
      always_comb begin
        if (closer[i] && !closer[i-1]) begin
          dist_ins[i]  = row_dist;
          lab_ins[i]   = label_r;
          valid_ins[i] = 1'b1;
        end else if (closer[i]) begin
          dist_ins[i]  = dist_r[i-1];
          lab_ins[i]   = lab_r[i-1];
          valid_ins[i] = valid_r[i-1];
        end else begin
          dist_ins[i]  = dist_r[i];
          lab_ins[i]   = lab_r[i];
          valid_ins[i] = valid_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < NEIGHBOURS; i++) begin
        dist_r[i] <= dist_ins[i];
        lab_r[i]  <= lab_ins[i];
      end
    end
  end

  // Valid bits and running vote counts. An insertion into a full list drops
  // the last entry from the list, so its label leaves the count.
  always_ff @(posedge clk) begin
    if (!rst_n || load_query || do_vote) begin
      valid_r <= '0;
      ones_r  <= '0;
      zeros_r <= '0;
    end else if (do_insert && (|closer)) begin
      valid_r <= valid_ins;
      if (valid_r[NEIGHBOURS-1]) begin
        if (lab_r[NEIGHBOURS-1]) begin
          ones_r <= ones_r - CW'(1) + CW'(label_r);
          zeros_r <= zeros_r + CW'(!label_r);
        end else begin
          ones_r <= ones_r + CW'(label_r);
          zeros_r <= zeros_r - CW'(1) + CW'(!label_r);
        end
      end else begin
        ones_r  <= ones_r + CW'(label_r);
        zeros_r <= zeros_r + CW'(!label_r);
      end
    end
  end

  // Output register holds one result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_vote) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_vote) begin
      out_data_r <= OUT_TDATA_W'({VOTE_W'(zeros_r), VOTE_W'(ones_r), (ones_r > zeros_r)});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/knn_vote_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the classifier. It keeps its own copy of the
// query and of the sorted neighbor list, predicts the vote for every last
// training row and compares each result transaction with the oldest prediction.
module knn_vote_checker
  import knnbc_pkg::*;
#(
  parameter int NEIGHBOURS = 5,
  parameter int FEATURES   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic              cls;
    logic [VOTE_W-1:0] ones;
    logic [VOTE_W-1:0] zeros;
  } vote_t;

  logic [FEAT_W-1:0] query_feat [FEAT_SLOTS];
  logic [DIST_W-1:0] near_span [NEIGHBOURS];
  logic              near_lab [NEIGHBOURS];
  logic              near_ok [NEIGHBOURS];
  vote_t             vote_q [$];
  int                errors = 0;

  assign fail_count = errors;

  // Empty the neighbor list, as a query load, a vote and reset all do.
  function automatic void clear_list();
    for (int i = 0; i < NEIGHBOURS; i++) begin
      near_span[i] = '0;
      near_lab[i]  = 1'b0;
      near_ok[i]   = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    logic [FEAT_W-1:0] a;
    logic [FEAT_W-1:0] b;
    logic [FEAT_W-1:0] d;
    logic [DIST_W-1:0] span;
    int                pos;
    int                ones;
    int                zeros;
    vote_t             want;

    if (!rst_n) begin
      for (int f = 0; f < FEAT_SLOTS; f++) query_feat[f] = '0;
      clear_list();
      vote_q.delete();
    end else begin
      // Result transaction: compare with the oldest predicted vote.
      if (out_tvalid && out_tready) begin
        if (vote_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no vote pending", out_tdata));
        end else begin
          want = vote_q.pop_front();
          if (out_tdata[0] !== want.cls)
            report_mismatch($sformatf("predicted_class %b, want %b", out_tdata[0], want.cls));
          if (out_tdata[VOTE_W:1] !== want.ones)
            report_mismatch($sformatf("votes_one %0d, want %0d",
                                      out_tdata[VOTE_W:1], want.ones));
          if (out_tdata[2*VOTE_W:VOTE_W+1] !== want.zeros)
            report_mismatch($sformatf("votes_zero %0d, want %0d",
                                      out_tdata[2*VOTE_W:VOTE_W+1], want.zeros));
        end
      end

      // Input transaction: update the query or the neighbor list.
      if (in_tvalid && in_tready) begin
        if (in_tuser == FUNC_QUERY) begin
          for (int f = 0; f < FEAT_SLOTS; f++) query_feat[f] = in_tdata[f*FEAT_W +: FEAT_W];
          clear_list();
        end else begin
          // Exact squared Euclidean distance over the used features.
          span = '0;
          for (int f = 0; f < FEATURES && f < FEAT_SLOTS; f++) begin
            a = query_feat[f];
            b = in_tdata[f*FEAT_W +: FEAT_W];
            d = (a >= b) ? a - b : b - a;
            span = span + DIST_W'(d) * DIST_W'(d);
          end

          // First free or strictly farther slot; ties keep the older row ahead.
          pos = NEIGHBOURS;
          for (int i = NEIGHBOURS - 1; i >= 0; i--)
            if (!near_ok[i] || span < near_span[i]) pos = i;
          if (pos < NEIGHBOURS) begin
            for (int i = NEIGHBOURS - 1; i > pos; i--) begin
              near_span[i] = near_span[i-1];
              near_lab[i]  = near_lab[i-1];
              near_ok[i]   = near_ok[i-1];
            end
            near_span[pos] = span;
            near_lab[pos]  = in_tdata[LABEL_BIT];
            near_ok[pos]   = 1'b1;
          end

          // The last row triggers the majority vote and starts a new pass.
          if (in_tlast) begin
            ones  = 0;
            zeros = 0;
            for (int i = 0; i < NEIGHBOURS; i++)
              if (near_ok[i]) begin
                if (near_lab[i]) ones++;
                else zeros++;
              end
            want.cls   = (ones > zeros);
            want.ones  = VOTE_W'(ones);
            want.zeros = VOTE_W'(zeros);
            vote_q.push_back(want);
            clear_list();
          end
        end
      end
    end
    pending <= vote_q.size();
  end

endmodule

>>> tb/knn_binary_classifier_test.sv
`timescale 1ns / 1ps

module knn_binary_classifier_test;
  import knnbc_pkg::*;

  localparam int NEIGHBOURS   = 5;
  localparam int FEATURES     = 8;
  localparam int TARGET_ITEMS = 1550;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 32;

  typedef logic [FEAT_SLOTS-1:0][FEAT_W-1:0] feat_vec_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int        fail_count;
  int        pending;
  int        items_sent = 0;
  int        idle_cycles = 0;
  bit        no_gaps = 1'b0;
  feat_vec_t query_now = '0;
  feat_vec_t prev_row = '0;

  knn_binary_classifier #(
    .NEIGHBOURS(NEIGHBOURS),
    .FEATURES  (FEATURES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  knn_vote_checker #(
    .NEIGHBOURS(NEIGHBOURS),
    .FEATURES  (FEATURES)
  ) vote_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: ready runs and stalls of random length, some long.
  initial begin : result_sink
    int choice;
    int run_len;
    forever begin
      choice = $urandom_range(0, 99);
      if (choice < 60) begin
        out_tready <= 1'b1;
        run_len = $urandom_range(1, 12);
      end else if (choice < 65) begin
        out_tready <= 1'b1;
        run_len = $urandom_range(100, 300);
      end else if (choice < 93) begin
        out_tready <= 1'b0;
        run_len = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        run_len = $urandom_range(10, 40);
      end
      repeat (run_len) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int choice;
    choice = $urandom_range(0, 99);
    if (no_gaps || choice < 55) return 0;
    if (choice < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one input item and hold it until the block takes the transaction.
  task automatic push_item(input logic func, input feat_vec_t feats,
                           input logic lab, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tlast  <= last;
    in_tdata  <= IN_TDATA_W'({lab, feats});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (func == FUNC_QUERY) query_now = feats;
    else prev_row = feats;
  endtask

  function automatic logic [FEAT_W-1:0] near_value(input logic [FEAT_W-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 30)) - 15;
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return FEAT_W'(v);
  endfunction

  function automatic feat_vec_t query_feats();
    feat_vec_t fv;
    int        choice;
    for (int f = 0; f < FEAT_SLOTS; f++) begin
      choice = $urandom_range(0, 9);
      if (choice < 6) fv[f] = FEAT_W'($urandom_range(0, 65535));
      else if (choice == 6) fv[f] = '0;
      else if (choice == 7) fv[f] = '1;
      else fv[f] = FEAT_W'($urandom_range(0, 255));
    end
    return fv;
  endfunction

  // Training rows: mostly near the query so that the list order matters,
  // with repeated rows to force equal distances.
  function automatic feat_vec_t row_feats();
    feat_vec_t fv;
    int        choice;
    choice = $urandom_range(0, 19);
    if (choice < 2) return prev_row;
    if (choice == 2) return query_now;
    for (int f = 0; f < FEAT_SLOTS; f++) begin
      choice = $urandom_range(0, 9);
      if (choice < 4) fv[f] = near_value(query_now[f]);
      else if (choice < 7) fv[f] = FEAT_W'($urandom_range(0, 65535));
      else if (choice == 7) fv[f] = '0;
      else if (choice == 8) fv[f] = '1;
      else fv[f] = query_now[f];
    end
    return fv;
  endfunction

  initial begin : stimulus
    feat_vec_t alt;
    feat_vec_t fv;
    int        rows;
    int        choice;
    int        pass_no;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_QUERY;
    in_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A row against the zero query after reset is at the largest distance.
    push_item(FUNC_ROW, '1, 1'b1, 1'b1);

    // Label and last are ignored on a query; two rows tie at the largest distance.
    push_item(FUNC_QUERY, '1, 1'b1, 1'b1);
    push_item(FUNC_ROW, '0, 1'b0, 1'b0);
    push_item(FUNC_ROW, '1, 1'b1, 1'b0);
    push_item(FUNC_ROW, '0, 1'b1, 1'b1);

    // Two ones against two zeros gives class zero.
    alt = {4{16'hFFFF, 16'h0000}};
    push_item(FUNC_QUERY, alt, 1'b0, 1'b0);
    push_item(FUNC_ROW, alt, 1'b1, 1'b0);
    push_item(FUNC_ROW, ~alt, 1'b0, 1'b0);
    push_item(FUNC_ROW, alt, 1'b1, 1'b0);
    push_item(FUNC_ROW, ~alt, 1'b0, 1'b1);

    // A query in the middle of a pass throws away the rows seen so far.
    push_item(FUNC_ROW, alt, 1'b1, 1'b0);
    push_item(FUNC_ROW, alt, 1'b1, 1'b0);
    push_item(FUNC_QUERY, {8{16'h8000}}, 1'b0, 1'b1);
    push_item(FUNC_ROW, {8{16'h7FFF}}, 1'b0, 1'b1);

    // More rows than the list holds: each closer row displaces the farthest,
    // and a far row arriving on a full list is dropped.
    push_item(FUNC_QUERY, {8{16'h1234}}, 1'b1, 1'b0);
    for (int k = 7; k >= 2; k--) begin
      fv = {8{16'(16'h1234 + k)}};
      push_item(FUNC_ROW, fv, 1'((k % 2)), 1'b0);
    end
    push_item(FUNC_ROW, '1, 1'b1, 1'b0);
    push_item(FUNC_ROW, {8{16'h1235}}, 1'b0, 1'b1);

    // Random passes: mostly well-formed query/rows/last sequences, some noise.
    pass_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      pass_no++;
      if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;

      // Now and then hold off until every pending vote has come out.
      if (pass_no % 40 == 20) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end

      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) < 8)
          push_item(FUNC_QUERY, query_feats(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        choice = $urandom_range(0, 99);
        if (choice < 10) rows = 1;
        else if (choice < 85) rows = $urandom_range(3, 9);
        else rows = $urandom_range(10, 16);
        for (int r = 1; r <= rows; r++)
          push_item(FUNC_ROW, row_feats(), 1'($urandom_range(0, 1)), r == rows);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) fv = query_feats();
          else fv = row_feats();
          push_item(1'($urandom_range(0, 1)), fv, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
    end

    // Let the last votes drain, then give the verdict.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
